// ===== design/lpg_pkg.sv =====
package lpg_pkg;

    localparam int COORD_BITS = 9;
    localparam int COLOR_BITS = 16;

    typedef logic [COLOR_BITS-1:0] t_color;

    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_STEP  = 1'b1
    } t_func;

    // step direction codes of one axis
    typedef logic [1:0] t_dir;
    localparam t_dir DIR_NONE = 2'd0;
    localparam t_dir DIR_UP   = 2'd1;
    localparam t_dir DIR_DOWN = 2'd3;

endpackage

// ===== design/lpg_if.sv =====
interface lpg_line_if #(
    parameter int COORD_BITS = lpg_pkg::COORD_BITS
);
    logic                   valid;
    logic                   ready;
    lpg_pkg::t_func         func;
    logic [COORD_BITS-1:0]  start_x;
    logic [COORD_BITS-1:0]  start_y;
    logic [COORD_BITS-1:0]  end_x;
    logic [COORD_BITS-1:0]  end_y;
    lpg_pkg::t_color        pen_color;

    modport source (output valid, func, start_x, start_y, end_x, end_y, pen_color,
                    input ready);
    modport sink   (input valid, func, start_x, start_y, end_x, end_y, pen_color,
                    output ready);
endinterface

interface lpg_pixel_if #(
    parameter int COORD_BITS = lpg_pkg::COORD_BITS
);
    logic                   valid;
    logic                   ready;
    logic [COORD_BITS-1:0]  pixel_x;
    logic [COORD_BITS-1:0]  pixel_y;
    lpg_pkg::t_color        pixel_color;
    logic                   last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel,
                    input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel,
                    output ready);
endinterface

// ===== design/lpg_setup.sv =====
module lpg_setup #(
    parameter int COORD_BITS = lpg_pkg::COORD_BITS
) (
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    output logic [COORD_BITS-1:0] o_abs_dx,
    output logic [COORD_BITS-1:0] o_abs_dy,
    output lpg_pkg::t_dir         o_col_dir,
    output lpg_pkg::t_dir         o_row_dir,
    output logic [COORD_BITS-1:0] o_major_dist,
    output logic [COORD_BITS:0]   o_pixels
);

    always_comb begin
        if (i_end_x > i_start_x) begin
            o_abs_dx  = i_end_x - i_start_x;
            o_col_dir = lpg_pkg::DIR_UP;
        end else if (i_end_x == i_start_x) begin
            o_abs_dx  = '0;
            o_col_dir = lpg_pkg::DIR_NONE;
        end else begin
            o_abs_dx  = i_start_x - i_end_x;
            o_col_dir = lpg_pkg::DIR_DOWN;
        end

        if (i_end_y > i_start_y) begin
            o_abs_dy  = i_end_y - i_start_y;
            o_row_dir = lpg_pkg::DIR_UP;
        end else if (i_end_y == i_start_y) begin
            o_abs_dy  = '0;
            o_row_dir = lpg_pkg::DIR_NONE;
        end else begin
            o_abs_dy  = i_start_y - i_end_y;
            o_row_dir = lpg_pkg::DIR_DOWN;
        end

        o_major_dist = (o_abs_dx > o_abs_dy) ? o_abs_dx : o_abs_dy;
        // start pixel is given twice, so distance + 2 pixels
        o_pixels     = {1'b0, o_major_dist} + (COORD_BITS+1)'(2);
    end

endmodule

// ===== design/lpg_core.sv =====
module lpg_core #(
    parameter int COORD_BITS = lpg_pkg::COORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_step,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    input  lpg_pkg::t_color       i_pen_color,
    output logic [COORD_BITS-1:0] o_col,
    output logic [COORD_BITS-1:0] o_row,
    output lpg_pkg::t_color       o_color,
    output logic                  o_last,
    output logic                  o_active
);

    logic [COORD_BITS-1:0] r_col, r_row, r_abs_dx, r_abs_dy, r_major;
    logic [COORD_BITS:0]   r_col_err, r_row_err, r_pixels_left;
    lpg_pkg::t_dir         r_col_dir, r_row_dir;
    lpg_pkg::t_color       r_color;
    logic                  r_active;

    logic [COORD_BITS-1:0] w_abs_dx, w_abs_dy, w_major;
    lpg_pkg::t_dir         w_col_dir, w_row_dir;
    logic [COORD_BITS:0]   w_pixels;

    logic [COORD_BITS-1:0] n_col, n_row;
    logic [COORD_BITS:0]   n_col_err, n_row_err, n_pixels_left;
    logic [COORD_BITS:0]   w_col_sum, w_row_sum, w_major_ext;

    lpg_setup #(.COORD_BITS(COORD_BITS)) u_setup (
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .o_abs_dx     (w_abs_dx),
        .o_abs_dy     (w_abs_dy),
        .o_col_dir    (w_col_dir),
        .o_row_dir    (w_row_dir),
        .o_major_dist (w_major),
        .o_pixels     (w_pixels)
    );

    always_comb begin
        w_major_ext = {1'b0, r_major};
        w_col_sum   = r_col_err + {1'b0, r_abs_dx};
        w_row_sum   = r_row_err + {1'b0, r_abs_dy};
        n_col_err   = w_col_sum;
        n_row_err   = w_row_sum;
        n_col       = r_col;
        n_row       = r_row;

        if (w_col_sum > w_major_ext) begin
            n_col_err = w_col_sum - w_major_ext;
            case (r_col_dir)
                lpg_pkg::DIR_UP:   n_col = r_col + 1'b1;
                lpg_pkg::DIR_DOWN: n_col = r_col - 1'b1;
                default:           n_col = r_col;
            endcase
        end

        if (w_row_sum > w_major_ext) begin
            n_row_err = w_row_sum - w_major_ext;
            case (r_row_dir)
                lpg_pkg::DIR_UP:   n_row = r_row + 1'b1;
                lpg_pkg::DIR_DOWN: n_row = r_row - 1'b1;
                default:           n_row = r_row;
            endcase
        end

        n_pixels_left = (r_pixels_left != '0) ? r_pixels_left - 1'b1 : r_pixels_left;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_start) begin
            r_active <= 1'b1;
        end else if (i_step && r_active) begin
            r_active <= (n_pixels_left != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_col         <= i_start_x;
            r_row         <= i_start_y;
            r_abs_dx      <= w_abs_dx;
            r_abs_dy      <= w_abs_dy;
            r_col_dir     <= w_col_dir;
            r_row_dir     <= w_row_dir;
            r_major       <= w_major;
            r_col_err     <= '0;
            r_row_err     <= '0;
            r_pixels_left <= w_pixels;
            r_color       <= i_pen_color;
        end else if (i_step && r_active) begin
            r_col         <= n_col;
            r_row         <= n_row;
            r_col_err     <= n_col_err;
            r_row_err     <= n_row_err;
            r_pixels_left <= n_pixels_left;
        end
    end

    assign o_col    = r_col;
    assign o_row    = r_row;
    assign o_color  = r_color;
    assign o_last   = (r_pixels_left == (COORD_BITS+1)'(1));
    assign o_active = r_active;

endmodule

// ===== design/line_pixel_generator.sv =====
// a step transfer is held in the input register, then its pixel is captured in the pixel register
//   as the line state advances; a start item gives no pixel
// throughput: one item per cycle while o_pixel.ready does not hold back the pixel register
// i_rst_n is synchronous, active low: clears the valid bits of both pipeline registers and the
//   line-active flag, so steps after reset give nothing until a start item arrives
module line_pixel_generator #(
    parameter int COORD_BITS = lpg_pkg::COORD_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpg_line_if.sink    i_line,
    lpg_pixel_if.source o_pixel
);

    logic                  r_in_valid;
    lpg_pkg::t_func        r_func;
    logic [COORD_BITS-1:0] r_start_x, r_start_y, r_end_x, r_end_y;
    lpg_pkg::t_color       r_pen_color;

    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_pixel_x, r_pixel_y;
    lpg_pkg::t_color       r_pixel_color;
    logic                  r_last_pixel;

    logic                  w_advance, w_start, w_step, w_emit;
    logic [COORD_BITS-1:0] w_col, w_row;
    lpg_pkg::t_color       w_color;
    logic                  w_last, w_active;

    // the held item moves on once the pixel register is free or being drained
    assign w_advance    = r_in_valid && (!r_out_valid || o_pixel.ready);
    assign w_start      = w_advance && (r_func == lpg_pkg::FUNC_START);
    assign w_step       = w_advance && (r_func == lpg_pkg::FUNC_STEP);
    assign w_emit       = w_step && w_active;
    assign i_line.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_line.ready) begin
            r_in_valid <= i_line.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_line.ready && i_line.valid) begin
            r_func      <= i_line.func;
            r_start_x   <= i_line.start_x;
            r_start_y   <= i_line.start_y;
            r_end_x     <= i_line.end_x;
            r_end_y     <= i_line.end_y;
            r_pen_color <= i_line.pen_color;
        end
    end

    lpg_core #(.COORD_BITS(COORD_BITS)) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_step      (w_step),
        .i_start_x   (r_start_x),
        .i_start_y   (r_start_y),
        .i_end_x     (r_end_x),
        .i_end_y     (r_end_y),
        .i_pen_color (r_pen_color),
        .o_col       (w_col),
        .o_row       (w_row),
        .o_color     (w_color),
        .o_last      (w_last),
        .o_active    (w_active)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_pixel.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_pixel_x     <= w_col;
            r_pixel_y     <= w_row;
            r_pixel_color <= w_color;
            r_last_pixel  <= w_last;
        end
    end

    assign o_pixel.valid       = r_out_valid;
    assign o_pixel.pixel_x     = r_pixel_x;
    assign o_pixel.pixel_y     = r_pixel_y;
    assign o_pixel.pixel_color = r_pixel_color;
    assign o_pixel.last_pixel  = r_last_pixel;

endmodule
